>>> hdl/kvp_pkg.sv
// ============================================================================
// kvp_pkg
// Shared types and constants for the inline key-value command parser.
// ============================================================================
package kvp_pkg;

    // Default longest command name that is still matched
    localparam int MAX_NAME_LENGTH_DEF = 6;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Token count saturates here
    localparam logic [2:0] TOKEN_SAT = 3'd4;

    // Command codes
    typedef enum logic [2:0] {
        CMD_SET    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_DEL    = 3'd2,
        CMD_EXISTS = 3'd3,
        CMD_EXPIRE = 3'd4,
        CMD_TTL    = 3'd5,
        CMD_SAVE   = 3'd6,
        CMD_QUIT   = 3'd7
    } t_cmd_code;

    // Verdict status
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_ARITY      = 3'd2,
        ST_BAD_EXPIRY = 3'd3,
        ST_UNKNOWN    = 3'd4
    } t_status;

    // Role of a byte as decided by the front end
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_NAME = 2'd1,
        KIND_ARG1 = 2'd2,
        KIND_ARG2 = 2'd3
    } t_byte_kind;

    // Queue entry: one classified byte and/or end of line
    typedef struct packed {
        t_byte_kind  kind;
        logic [7:0]  data;    // upper-cased for name bytes
        logic        eol;
        logic [2:0]  tokens;  // token count including this byte
    } t_cmd_item;

    // Command names, first character in the lowest byte, zero padded
    localparam logic [47:0] CMD_NAME [8] = '{
        48'h000000544553,   // SET
        48'h000000544547,   // GET
        48'h0000004C4544,   // DEL
        48'h535453495845,   // EXISTS
        48'h455249505845,   // EXPIRE
        48'h0000004C5454,   // TTL
        48'h000045564153,   // SAVE
        48'h000054495551    // QUIT
    };

    // Name lengths in characters
    localparam logic [2:0] CMD_LEN [8] = '{
        3'd3, 3'd3, 3'd3, 3'd6, 3'd6, 3'd3, 3'd4, 3'd4
    };

    // Required token count per command
    localparam logic [2:0] CMD_TOKENS [8] = '{
        3'd3, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2, 3'd1, 3'd1
    };

endpackage

>>> hdl/kvp_ifs.sv
// ============================================================================
// kvp_in_if / kvp_out_if
// Valid/ready channels for command bytes in and parse results out.
// ============================================================================

// Command byte channel
interface kvp_in_if ();
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       byte_present;
    logic       end_of_line;

    modport source (output valid, line_byte, byte_present, end_of_line, input ready);
    modport sink   (input valid, line_byte, byte_present, end_of_line, output ready);
endinterface

// Result channel
interface kvp_out_if ();
    logic                 valid;
    logic                 ready;
    logic                 arg_valid;
    logic [7:0]           arg_byte;
    logic [1:0]           arg_number;
    logic                 verdict_valid;
    kvp_pkg::t_cmd_code   command_code;
    kvp_pkg::t_status     status;
    logic [62:0]          expiry_seconds;

    modport source (output valid, arg_valid, arg_byte, arg_number, verdict_valid,
                    command_code, status, expiry_seconds, input ready);
    modport sink   (input valid, arg_valid, arg_byte, arg_number, verdict_valid,
                    command_code, status, expiry_seconds, output ready);
endinterface

>>> hdl/inline_kv_command_parser.sv
// ============================================================================
// inline_kv_command_parser
// Byte-stream command line parser: tokenizer, queue, executor.
// ============================================================================
// Takes one command-line byte per cycle and never stalls on its own: a new
// byte is accepted every cycle while the two-entry queue between the
// tokenizer and the executor has room, so the rate is one item per cycle as
// long as results are taken. Spaces and bytes of surplus tokens are consumed
// by the tokenizer and never reach the queue. A result (argument byte and/or
// end-of-line verdict) passes through the queue and the executor's result
// register: its byte is written into the queue when it is accepted and
// loaded into the result register when the executor pops it. The executor
// parses the expiry with a shift-and-add decimal step and matches the command
// name against fixed tables combinationally at end of line.
// ============================================================================
module inline_kv_command_parser #(
    parameter int MAX_NAME_LENGTH = kvp_pkg::MAX_NAME_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kvp_in_if.sink    i_cmd,
    kvp_out_if.source o_res
);

    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    kvp_pkg::t_cmd_item q_in_item;
    kvp_pkg::t_cmd_item q_out_item;

    // Tokenizer
    kvp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (q_in_item)
    );

    // Decoupling queue
    kvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    // Executor and result register
    kvp_back #(
        .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_out_item),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

    // Queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // Every result carries an argument byte or a verdict
    a_result_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.arg_valid || o_res.verdict_valid))
        else $error("empty result transfer");

    // Argument bytes are tagged 1 or 2
    a_arg_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.arg_valid) |->
            (o_res.arg_number == 2'd1 || o_res.arg_number == 2'd2))
        else $error("bad argument number");

    // A nonzero expiry only comes with an accepted EXPIRE
    a_expiry_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.expiry_seconds != 63'd0) |->
            (o_res.verdict_valid && o_res.command_code == kvp_pkg::CMD_EXPIRE &&
             o_res.status == kvp_pkg::ST_OK))
        else $error("expiry on a non-EXPIRE verdict");

endmodule

>>> hdl/kvp_front.sv
// ============================================================================
// kvp_front
// Tokenizer: tracks token boundaries, tags each byte with its role and
// forwards only bytes that matter (name, argument 1/2, end of line).
// ============================================================================
module kvp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    kvp_in_if.sink              i_cmd,
    input  logic                i_q_full,
    output logic                o_push,
    output kvp_pkg::t_cmd_item  o_item
);

    logic [2:0] r_count, n_count;
    logic       r_inside, n_inside;
    logic       accept;
    logic       is_space;
    logic       is_lower;
    kvp_pkg::t_byte_kind kind;
    logic [7:0] data;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Character classes (C locale)
    assign is_space = (i_cmd.line_byte == 8'h20) ||
                      (i_cmd.line_byte >= 8'h09 && i_cmd.line_byte <= 8'h0D);
    assign is_lower = (i_cmd.line_byte >= 8'h61) && (i_cmd.line_byte <= 8'h7A);

    // Classify byte and advance token state
    always_comb begin
        n_count  = r_count;
        n_inside = r_inside;
        kind     = kvp_pkg::KIND_NONE;
        data     = i_cmd.line_byte;
        if (i_cmd.byte_present) begin
            if (is_space) begin
                n_inside = 1'b0;
            end else begin
                if (!r_inside) begin
                    n_inside = 1'b1;
                    if (r_count < kvp_pkg::TOKEN_SAT) begin
                        n_count = r_count + 3'd1;
                    end
                end
                case (n_count)
                    3'd1: begin
                        kind = kvp_pkg::KIND_NAME;
                        data = is_lower ? (i_cmd.line_byte - 8'd32) : i_cmd.line_byte;
                    end
                    3'd2:    kind = kvp_pkg::KIND_ARG1;
                    3'd3:    kind = kvp_pkg::KIND_ARG2;
                    default: kind = kvp_pkg::KIND_NONE;
                endcase
            end
        end
        o_item.kind   = kind;
        o_item.data   = data;
        o_item.eol    = i_cmd.end_of_line;
        o_item.tokens = n_count;
        o_push        = accept && (i_cmd.end_of_line || (kind != kvp_pkg::KIND_NONE));
        // Line done: start over
        if (i_cmd.end_of_line) begin
            n_count  = 3'd0;
            n_inside = 1'b0;
        end
    end

    // Token state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 3'd0;
            r_inside <= 1'b0;
        end else if (accept) begin
            r_count  <= n_count;
            r_inside <= n_inside;
        end
    end

endmodule

>>> hdl/kvp_queue.sv
// ============================================================================
// kvp_queue
// Small FIFO of classified bytes between tokenizer and executor.
// ============================================================================
module kvp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  kvp_pkg::t_cmd_item  i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output kvp_pkg::t_cmd_item  o_item
);

    localparam int PTR_W = (kvp_pkg::QUEUE_DEPTH > 1) ? $clog2(kvp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(kvp_pkg::QUEUE_DEPTH + 1);

    kvp_pkg::t_cmd_item r_mem [kvp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(kvp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(kvp_pkg::QUEUE_DEPTH - 1)) ? '0
                            : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(kvp_pkg::QUEUE_DEPTH - 1)) ? '0
                            : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/kvp_back.sv
// ============================================================================
// kvp_back
// Executor: collects the command name, parses the expiry argument,
// forms the verdict at end of line and holds the result register.
// ============================================================================
module kvp_back #(
    parameter int MAX_NAME_LENGTH = kvp_pkg::MAX_NAME_LENGTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  kvp_pkg::t_cmd_item  i_item,
    output logic                o_pop,
    kvp_out_if.source           o_res
);

    localparam int NAME_BITS = MAX_NAME_LENGTH * 8;
    localparam int LEN_W     = $clog2(MAX_NAME_LENGTH + 2);

    // Line state
    logic [NAME_BITS-1:0] r_name, n_name;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [62:0]          r_num, n_num;
    logic                 r_neg, n_neg;
    logic                 r_has_digit, n_has_digit;
    logic                 r_bad, n_bad;

    // Result register
    logic                 r_out_valid;
    logic                 r_arg_valid, n_arg_valid;
    logic [7:0]           r_arg_byte, n_arg_byte;
    logic [1:0]           r_arg_number, n_arg_number;
    logic                 r_verdict, n_verdict;
    kvp_pkg::t_cmd_code   r_code, n_code;
    kvp_pkg::t_status     r_status, n_status;
    logic [62:0]          r_expiry, n_expiry;

    logic        produces;
    logic        load;
    logic        is_arg;
    logic [66:0] num_sum;
    logic [63:0] name_ext;
    logic        found;
    logic [2:0]  hit_idx;

    assign is_arg   = (i_item.kind == kvp_pkg::KIND_ARG1) || (i_item.kind == kvp_pkg::KIND_ARG2);
    assign produces = i_item.eol || is_arg;
    assign o_pop    = i_valid && (!produces || !r_out_valid || o_res.ready);
    assign load     = o_pop && produces;

    // Decimal accumulate: value * 10 + digit, wide enough to see overflow
    assign num_sum = ({4'b0, r_num} << 3) + ({4'b0, r_num} << 1) + 67'(i_item.data[3:0]);

    // Per-item update and verdict
    always_comb begin
        n_name      = r_name;
        n_len       = r_len;
        n_num       = r_num;
        n_neg       = r_neg;
        n_has_digit = r_has_digit;
        n_bad       = r_bad;

        // Command name bytes
        if (i_item.kind == kvp_pkg::KIND_NAME) begin
            if (r_len < LEN_W'(MAX_NAME_LENGTH)) begin
                for (int j = 0; j < MAX_NAME_LENGTH; j++) begin
                    if (r_len == LEN_W'(j)) begin
                        n_name[j*8 +: 8] = i_item.data;
                    end
                end
                n_len = r_len + LEN_W'(1);
            end else begin
                n_len = LEN_W'(MAX_NAME_LENGTH + 1);
            end
        end

        // Expiry argument bytes
        if (i_item.kind == kvp_pkg::KIND_ARG2 && !r_bad) begin
            if (i_item.data == 8'h2D) begin
                if (r_neg || r_has_digit) begin
                    n_bad = 1'b1;
                end else begin
                    n_neg = 1'b1;
                end
            end else if (i_item.data >= 8'h30 && i_item.data <= 8'h39) begin
                if (num_sum[66:63] != 4'd0) begin
                    n_bad = 1'b1;
                end else begin
                    n_num = num_sum[62:0];
                end
                n_has_digit = 1'b1;
            end else begin
                n_bad = 1'b1;
            end
        end

        // Name lookup; names are zero padded past their length
        name_ext = 64'(n_name);
        found    = 1'b0;
        hit_idx  = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (!found && (32'(kvp_pkg::CMD_LEN[k]) <= MAX_NAME_LENGTH) &&
                (n_len == LEN_W'(kvp_pkg::CMD_LEN[k])) &&
                (name_ext[47:0] == kvp_pkg::CMD_NAME[k])) begin
                found   = 1'b1;
                hit_idx = 3'(k);
            end
        end

        // Result fields
        n_arg_valid  = is_arg;
        n_arg_byte   = is_arg ? i_item.data : 8'd0;
        n_arg_number = (i_item.kind == kvp_pkg::KIND_ARG1) ? 2'd1 :
                       (i_item.kind == kvp_pkg::KIND_ARG2) ? 2'd2 : 2'd0;
        n_verdict    = i_item.eol;
        n_code       = kvp_pkg::CMD_SET;
        n_status     = kvp_pkg::ST_OK;
        n_expiry     = 63'd0;
        if (i_item.eol) begin
            if (i_item.tokens == 3'd0) begin
                n_status = kvp_pkg::ST_EMPTY;
            end else if (!found) begin
                n_status = kvp_pkg::ST_UNKNOWN;
            end else begin
                n_code = kvp_pkg::t_cmd_code'(hit_idx);
                if (i_item.tokens != kvp_pkg::CMD_TOKENS[hit_idx]) begin
                    n_status = kvp_pkg::ST_ARITY;
                end else if (n_code == kvp_pkg::CMD_EXPIRE) begin
                    if (!n_has_digit || n_bad || (n_neg && n_num != 63'd0)) begin
                        n_status = kvp_pkg::ST_BAD_EXPIRY;
                    end else begin
                        n_expiry = n_num;
                    end
                end
            end
            // Clear line state for the next line
            n_name      = '0;
            n_len       = '0;
            n_num       = '0;
            n_neg       = 1'b0;
            n_has_digit = 1'b0;
            n_bad       = 1'b0;
        end
    end

    // Line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name      <= '0;
            r_len       <= '0;
            r_num       <= '0;
            r_neg       <= 1'b0;
            r_has_digit <= 1'b0;
            r_bad       <= 1'b0;
        end else if (o_pop) begin
            r_name      <= n_name;
            r_len       <= n_len;
            r_num       <= n_num;
            r_neg       <= n_neg;
            r_has_digit <= n_has_digit;
            r_bad       <= n_bad;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_arg_valid  <= n_arg_valid;
            r_arg_byte   <= n_arg_byte;
            r_arg_number <= n_arg_number;
            r_verdict    <= n_verdict;
            r_code       <= n_code;
            r_status     <= n_status;
            r_expiry     <= n_expiry;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.arg_valid      = r_arg_valid;
    assign o_res.arg_byte       = r_arg_byte;
    assign o_res.arg_number     = r_arg_number;
    assign o_res.verdict_valid  = r_verdict;
    assign o_res.command_code   = r_code;
    assign o_res.status         = r_status;
    assign o_res.expiry_seconds = r_expiry;

endmodule
